// ----- rtl/zhhb_pkg.sv -----
// ----------------------------------------------------------------------------
// zhhb_pkg
// Types, character codes and helper functions shared by the hex header
// builder modules.
// ----------------------------------------------------------------------------
package zhhb_pkg;

    localparam int unsigned HDR_BYTES  = 5;
    localparam int unsigned REC_BYTES  = 7;
    localparam int unsigned CHAR_COUNT = 17;

    localparam logic [15:0] CRC_SEED = 16'h0000;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] START_CHAR = 8'h42;
    localparam logic [7:0] CR_CHAR    = 8'h0d;
    localparam logic [7:0] LF_CHAR    = 8'h0a;
    localparam logic [7:0] HIGH_BIT   = 8'h80;
    localparam logic [7:0] DIGIT_BASE = 8'h30;
    localparam logic [7:0] ALPHA_BASE = 8'h57;

    // character positions within one header
    localparam logic [4:0] START_IDX = 5'd0;
    localparam logic [4:0] CR_IDX    = 5'd15;
    localparam logic [4:0] LF_IDX    = 5'd16;

    // byte 0 = type, 1..4 = f3..f0, 5 = crc high, 6 = crc low
    typedef logic [REC_BYTES-1:0][7:0] hdr_rec_t;
    typedef logic [4:0]                char_idx_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'h0, nib};
        return (nib < 4'd10) ? (DIGIT_BASE + n8) : (ALPHA_BASE + n8);
    endfunction

    function automatic logic [7:0] char_at(input hdr_rec_t rec, input char_idx_t idx);
        char_idx_t  k;
        logic [7:0] b;
        logic [7:0] ch;
        k  = idx - 5'd1;
        b  = rec[k[3:1]];
        ch = 8'h00;
        case (idx)
            START_IDX: ch = START_CHAR;
            CR_IDX:    ch = CR_CHAR;
            LF_IDX:    ch = LF_CHAR | HIGH_BIT;
            default:   ch = k[0] ? hex_char(b[3:0]) : hex_char(b[7:4]);
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/zhhb_if.sv -----
// ----------------------------------------------------------------------------
// zhhb_if
// Valid/ready channels of the hex header builder: header in, characters out.
// ----------------------------------------------------------------------------
interface zhhb_hdr_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_type;
    logic [7:0] flag3;
    logic [7:0] flag2;
    logic [7:0] flag1;
    logic [7:0] flag0;

    modport source (output valid, frame_type, flag3, flag2, flag1, flag0, input ready);
    modport sink   (input valid, frame_type, flag3, flag2, flag1, flag0, output ready);
endinterface

interface zhhb_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, out_char, last_char, input ready);
    modport sink   (input valid, out_char, last_char, output ready);
endinterface

// ----- rtl/zhhb_front.sv -----
// ----------------------------------------------------------------------------
// zhhb_front
// Accepts a header and runs CRC-16/XMODEM over its five bytes, one byte per
// cycle, then hands the finished record to the queue.
// ----------------------------------------------------------------------------
module zhhb_front
(
    input  logic                clk,
    input  logic                rst_n,
    zhhb_hdr_if.sink            hdr,
    output logic                push_valid,
    input  logic                push_ready,
    output zhhb_pkg::hdr_rec_t  push_rec
);

    logic                                     busy_reg, busy_next;
    logic [2:0]                               cnt_reg, cnt_next;
    logic [zhhb_pkg::HDR_BYTES-1:0][7:0]      bytes_reg, bytes_next;
    logic [15:0]                              crc_reg, crc_next;
    logic                                     accept;
    logic                                     done;

    assign hdr.ready  = !busy_reg;
    assign accept     = hdr.valid && !busy_reg;
    assign done       = busy_reg && (cnt_reg == 3'(zhhb_pkg::HDR_BYTES));
    assign push_valid = done;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        crc_next   = crc_reg;
        if (accept)
        begin
            busy_next  = 1'b1;
            cnt_next   = 3'd1;
            bytes_next = {hdr.flag0, hdr.flag1, hdr.flag2, hdr.flag3, hdr.frame_type};
            crc_next   = zhhb_pkg::crc_byte(zhhb_pkg::CRC_SEED, hdr.frame_type);
        end
        else if (busy_reg && !done)
        begin
            cnt_next = cnt_reg + 3'd1;
            crc_next = zhhb_pkg::crc_byte(crc_reg, bytes_reg[cnt_reg]);
        end
        else if (done && push_ready)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        push_rec = {crc_reg[7:0], crc_reg[15:8], bytes_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        crc_reg   <= crc_next;
    end

endmodule

// ----- rtl/zhhb_queue.sv -----
// ----------------------------------------------------------------------------
// zhhb_queue
// Two-entry record queue between the CRC front end and the serializer.
// ----------------------------------------------------------------------------
module zhhb_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  zhhb_pkg::hdr_rec_t  push_rec,
    output logic                pop_valid,
    input  logic                pop_ready,
    output zhhb_pkg::hdr_rec_t  pop_rec
);

    zhhb_pkg::hdr_rec_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg, count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_rec    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ----- rtl/zhhb_back.sv -----
// ----------------------------------------------------------------------------
// zhhb_back
// Serializer: turns one record into 17 characters, one per cycle while
// chr.ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module zhhb_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  zhhb_pkg::hdr_rec_t  pop_rec,
    zhhb_chr_if.source          chr
);

    zhhb_pkg::hdr_rec_t  rec_reg;
    zhhb_pkg::char_idx_t idx_reg, idx_next;
    logic                active_reg, active_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;
    logic                adv;
    logic                at_last;

    assign adv       = active_reg && (!out_valid_reg || chr.ready);
    assign at_last   = (idx_reg == zhhb_pkg::LF_IDX);
    assign pop_ready = !active_reg || (adv && at_last);

    assign chr.valid     = out_valid_reg;
    assign chr.out_char  = out_char_reg;
    assign chr.last_char = out_last_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_char_next  = zhhb_pkg::char_at(rec_reg, idx_reg);
            out_last_next  = at_last;
            idx_next       = idx_reg + 5'd1;
            if (at_last)
            begin
                active_next = 1'b0;
            end
        end
        else if (chr.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop_valid && pop_ready)
        begin
            active_next = 1'b1;
            idx_next    = zhhb_pkg::START_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= zhhb_pkg::START_IDX;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (pop_valid && pop_ready)
        begin
            rec_reg <= pop_rec;
        end
    end

endmodule

// ----- rtl/zmodem_hex_header_builder.sv -----
// ----------------------------------------------------------------------------
// zmodem_hex_header_builder
// Builds a ZMODEM hex header with CRC-16/XMODEM from a type and four flags.
// ----------------------------------------------------------------------------
// Usage:
//   hdr: valid/ready channel carrying frame_type and flag3..flag0; a header
//        is taken at a clock edge with valid and ready both high.
//   chr: valid/ready channel carrying out_char and last_char; one transfer
//        per character, 17 per header: 'B', fourteen lowercase hex digits
//        (type, f3..f0, crc high, crc low), CR, then LF with bit 7 set,
//        which carries last_char.
//   The first character follows the header transfer through the five CRC
//   byte steps, the queue, the serializer and the output register.
//   Throughput: set by the serializer emitting one character per cycle while
//   chr.ready is high; the CRC front end finishes a header sooner, and a
//   two-entry queue lets it take the next header while characters flow.
//   Reset: rst_n clears all control state; no header is pending afterward.
//   Stall: with chr.ready low the output character holds; the queue fills,
//   then hdr.ready drops until space returns.
// ----------------------------------------------------------------------------
module zmodem_hex_header_builder
(
    input  logic        clk,
    input  logic        rst_n,
    zhhb_hdr_if.sink    hdr,
    zhhb_chr_if.source  chr
);

    logic               q_push_valid;
    logic               q_push_ready;
    zhhb_pkg::hdr_rec_t q_push_rec;
    logic               q_pop_valid;
    logic               q_pop_ready;
    zhhb_pkg::hdr_rec_t q_pop_rec;

    zhhb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .hdr        (hdr),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_rec   (q_push_rec)
    );

    zhhb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_rec   (q_push_rec),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_rec    (q_pop_rec)
    );

    zhhb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_rec   (q_pop_rec),
        .chr       (chr)
    );

    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        chr.valid && chr.last_char |-> chr.out_char == (zhhb_pkg::LF_CHAR | zhhb_pkg::HIGH_BIT))
        else $error("last character is not LF|0x80");

    a_next_starts: assert property (@(posedge clk) disable iff (!rst_n)
        chr.valid && chr.ready && chr.last_char
        |=> !chr.valid || chr.out_char == zhhb_pkg::START_CHAR)
        else $error("header does not start with B");

    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_rec))
        else $error("front dropped a stalled record");

endmodule

// ----- tb/hex_header_checker.sv -----
// ----------------------------------------------------------------------------
// hex_header_checker
// Watches the header and character channels of the hex header builder. Each
// header transfer is expanded into its 17 characters ('B', hex digits of type,
// flags and CRC-16/XMODEM, CR, LF with bit 7 set). Each character transfer is
// then compared with the oldest expected character.
// ----------------------------------------------------------------------------
module hex_header_checker
(
    input  logic clk,
    input  logic rst_n,
    zhhb_hdr_if  hdr,
    zhhb_chr_if  chr,
    output int   error_count,
    output int   pending,
    output int   chars_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [7:0] ch;
        logic       last;
    } hdr_char_t;

    hdr_char_t expected_chars[$];

    function automatic logic [15:0] xmodem_crc_update(input logic [15:0] crc,
                                                      input logic [7:0]  data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ data[i];
            r  = {r[14:0], 1'b0};
            if (fb)
            begin
                r = r ^ zhhb_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 8'h30 | {4'h0, nib};
        end
        return 8'h61 + {4'h0, nib} - 8'd10;
    endfunction

    task automatic push_header_chars(input logic [7:0] t, f3, f2, f1, f0);
        logic [7:0]  rec [0:6];
        logic [15:0] crc;
        rec[0] = t;
        rec[1] = f3;
        rec[2] = f2;
        rec[3] = f1;
        rec[4] = f0;
        crc = zhhb_pkg::CRC_SEED;
        for (int i = 0; i < 5; i++)
        begin
            crc = xmodem_crc_update(crc, rec[i]);
        end
        rec[5] = crc[15:8];
        rec[6] = crc[7:0];
        expected_chars.push_back('{ch: zhhb_pkg::START_CHAR, last: 1'b0});
        for (int i = 0; i < 7; i++)
        begin
            expected_chars.push_back('{ch: ascii_hex(rec[i][7:4]), last: 1'b0});
            expected_chars.push_back('{ch: ascii_hex(rec[i][3:0]), last: 1'b0});
        end
        expected_chars.push_back('{ch: zhhb_pkg::CR_CHAR, last: 1'b0});
        expected_chars.push_back('{ch: zhhb_pkg::LF_CHAR | zhhb_pkg::HIGH_BIT,
                                   last: 1'b1});
    endtask

    always @(posedge clk)
    begin
        hdr_char_t exp_c;
        int        errs;
        errs = 0;
        if (!rst_n)
        begin
            error_count <= 0;
            pending     <= 0;
            chars_seen  <= 0;
        end
        else
        begin
            if (chr.valid && chr.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character transfer: out_char %h last_char %b",
                           chr.out_char, chr.last_char);
                    errs++;
                end
                else
                begin
                    exp_c = expected_chars.pop_front();
                    if (chr.out_char !== exp_c.ch)
                    begin
                        $error("out_char: expected %h, actual %h", exp_c.ch, chr.out_char);
                        errs++;
                    end
                    if (chr.last_char !== exp_c.last)
                    begin
                        $error("last_char: expected %b, actual %b",
                               exp_c.last, chr.last_char);
                        errs++;
                    end
                end
                chars_seen <= chars_seen + 1;
            end
            if (hdr.valid && hdr.ready)
            begin
                push_header_chars(hdr.frame_type, hdr.flag3, hdr.flag2,
                                  hdr.flag1, hdr.flag0);
            end
            error_count <= error_count + errs;
            pending     <= expected_chars.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the ZMODEM hex header builder. Directed headers
// hit byte extremes and hex digit boundaries, then random headers follow with
// random idle cycles on both channels, a stretch without idling and full
// drains of the character stream. Checking is done by hex_header_checker.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_HEADERS = 117;
    localparam int STALL_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 24;

    logic clk = 1'b0;
    logic rst_n;
    logic burst_mode = 1'b0;
    int   headers_sent = 0;
    int   idle_cycles = 0;
    int   error_count;
    int   pending;
    int   chars_seen;

    zhhb_hdr_if hdr();
    zhhb_chr_if chr();

    zmodem_hex_header_builder dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr),
        .chr   (chr)
    );

    hex_header_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .hdr         (hdr),
        .chr         (chr),
        .error_count (error_count),
        .pending     (pending),
        .chars_seen  (chars_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // character receiver
    initial
    begin
        chr.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            chr.ready <= burst_mode || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk)
    begin
        if ((hdr.valid && hdr.ready) || (chr.valid && chr.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [7:0] random_field();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_header(input logic [7:0] t, f3, f2, f1, f0);
        if (!burst_mode)
        begin
            while ($urandom_range(99) < 24)
            begin
                hdr.valid <= 1'b0;
                @(posedge clk);
            end
        end
        hdr.valid      <= 1'b1;
        hdr.frame_type <= t;
        hdr.flag3      <= f3;
        hdr.flag2      <= f2;
        hdr.flag1      <= f1;
        hdr.flag0      <= f0;
        @(posedge clk);
        while (!hdr.ready)
        begin
            @(posedge clk);
        end
        headers_sent++;
    endtask

    task automatic drain_chars();
        hdr.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        hdr.valid      = 1'b0;
        hdr.frame_type = 8'h00;
        hdr.flag3      = 8'h00;
        hdr.flag2      = 8'h00;
        hdr.flag1      = 8'h00;
        hdr.flag0      = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte extremes, one field at a time, nibble digit/letter boundaries
        send_header(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_header(8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_header(8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
        send_header(8'h00, 8'hff, 8'h00, 8'h00, 8'h00);
        send_header(8'h00, 8'h00, 8'hff, 8'h00, 8'h00);
        send_header(8'h00, 8'h00, 8'h00, 8'hff, 8'h00);
        send_header(8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
        send_header(8'h09, 8'h0a, 8'h90, 8'ha0, 8'h99);
        send_header(8'haa, 8'h55, 8'haa, 8'h55, 8'haa);
        send_header(8'h55, 8'haa, 8'h55, 8'haa, 8'h55);
        send_header(8'h01, 8'h02, 8'h04, 8'h08, 8'h10);
        send_header(8'h20, 8'h40, 8'h80, 8'h7f, 8'hfe);
        send_header(8'h0a, 8'h00, 8'h00, 8'h00, 8'h00);
        drain_chars();

        for (int n = 0; n < RANDOM_HEADERS; n++)
        begin
            burst_mode = (n >= 40) && (n < 80);
            if (n == 95)
            begin
                drain_chars();
            end
            send_header(random_field(), random_field(), random_field(),
                        random_field(), random_field());
        end
        burst_mode = 1'b0;
        drain_chars();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d headers (%0d characters checked), directed extremes",
                 headers_sent, chars_seen);
        $display("and random content under random stalls, one no-idle burst and drains.");
        if (error_count == 0 && pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/zhhb_pkg.sv
rtl/zhhb_if.sv
rtl/zhhb_front.sv
rtl/zhhb_queue.sv
rtl/zhhb_back.sv
rtl/zmodem_hex_header_builder.sv
tb/hex_header_checker.sv
tb/tb_top.sv
